// File: design/idsc_pkg.sv
// ---------------------------------------------------------------------------
// idsc_pkg
// Shared types, constants, gamma table function and microcode program for the
// idle dim / sleep controller.
// ---------------------------------------------------------------------------
package idsc_pkg;

  // default parameter values
  localparam int unsigned TIME_BITS_DEF   = 32;
  localparam int unsigned GAMMA_DEPTH_DEF = 256;

  // field widths
  localparam int unsigned NOW_W   = 32;
  localparam int unsigned CFG_W   = 24;
  localparam int unsigned REG_IDX_W = 2;
  localparam int unsigned Q16_W   = 17;  // 0..65536
  localparam int unsigned DIV_CNT_W = 5;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_DIM_START = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_SLEEP     = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_FADE      = 2'd2;

  // register reset values
  localparam logic [CFG_W-1:0] DIM_START_RST = 24'd30000;
  localparam logic [CFG_W-1:0] SLEEP_RST     = 24'd60000;
  localparam logic [CFG_W-1:0] FADE_RST      = 24'd30000;

  // power modes as reported on the result
  localparam logic [1:0] MODE_ACTIVE  = 2'd0;
  localparam logic [1:0] MODE_DIMMING = 2'd1;
  localparam logic [1:0] MODE_SLEEP   = 2'd2;

  localparam logic [7:0] CONTRAST_FULL = 8'd255;
  localparam logic [7:0] CONTRAST_GAIN = 8'd254;
  localparam logic [Q16_W-1:0] Q16_ONE = 17'h10000;
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS = 5'd16;

  // microcode
  typedef enum logic [3:0] {
    OP_WAIT,
    OP_IDLE,
    OP_NOP,
    OP_ELAPSED,
    OP_DIVSTEP,
    OP_SAT,
    OP_REST,
    OP_INDEX,
    OP_LOOKUP,
    OP_SCALE,
    OP_DIMOUT,
    OP_ACTIVITY,
    OP_ACTIVE,
    OP_SLEEP
  } op_e;

  typedef enum logic [2:0] {
    C_NONE,
    C_ALWAYS,
    C_FUNC,
    C_LT_DIM,
    C_GE_SLEEP,
    C_REM_GE,
    C_MORE
  } cond_e;

  typedef logic [3:0] step_t;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    step_t target;
  } ucode_t;

  localparam step_t STEP_WAIT     = 4'd0;
  localparam step_t STEP_IDLE     = 4'd1;
  localparam step_t STEP_CMP_DIM  = 4'd2;
  localparam step_t STEP_CMP_SLP  = 4'd3;
  localparam step_t STEP_ELAPSED  = 4'd4;
  localparam step_t STEP_CHK_SAT  = 4'd5;
  localparam step_t STEP_DIV      = 4'd6;
  localparam step_t STEP_REST     = 4'd7;
  localparam step_t STEP_INDEX    = 4'd8;
  localparam step_t STEP_LOOKUP   = 4'd9;
  localparam step_t STEP_SCALE    = 4'd10;
  localparam step_t STEP_DIMOUT   = 4'd11;
  localparam step_t STEP_SAT      = 4'd12;
  localparam step_t STEP_ACTIVITY = 4'd13;
  localparam step_t STEP_ACTIVE   = 4'd14;
  localparam step_t STEP_SLEEP    = 4'd15;

  // program store
  function automatic ucode_t ucode(step_t step);
    ucode_t w;
    unique case (step)
      STEP_WAIT:     w = '{OP_WAIT,     C_NONE,     STEP_WAIT};
      STEP_IDLE:     w = '{OP_IDLE,     C_FUNC,     STEP_ACTIVITY};
      STEP_CMP_DIM:  w = '{OP_NOP,      C_LT_DIM,   STEP_ACTIVE};
      STEP_CMP_SLP:  w = '{OP_NOP,      C_GE_SLEEP, STEP_SLEEP};
      STEP_ELAPSED:  w = '{OP_ELAPSED,  C_NONE,     STEP_WAIT};
      STEP_CHK_SAT:  w = '{OP_NOP,      C_REM_GE,   STEP_SAT};
      STEP_DIV:      w = '{OP_DIVSTEP,  C_MORE,     STEP_DIV};
      STEP_REST:     w = '{OP_REST,     C_NONE,     STEP_WAIT};
      STEP_INDEX:    w = '{OP_INDEX,    C_NONE,     STEP_WAIT};
      STEP_LOOKUP:   w = '{OP_LOOKUP,   C_NONE,     STEP_WAIT};
      STEP_SCALE:    w = '{OP_SCALE,    C_NONE,     STEP_WAIT};
      STEP_DIMOUT:   w = '{OP_DIMOUT,   C_ALWAYS,   STEP_WAIT};
      STEP_SAT:      w = '{OP_SAT,      C_ALWAYS,   STEP_REST};
      STEP_ACTIVITY: w = '{OP_ACTIVITY, C_ALWAYS,   STEP_WAIT};
      STEP_ACTIVE:   w = '{OP_ACTIVE,   C_ALWAYS,   STEP_WAIT};
      STEP_SLEEP:    w = '{OP_SLEEP,    C_ALWAYS,   STEP_WAIT};
    endcase
    return w;
  endfunction

  // gamma 2.2 table entry, Q1.16, evaluated at elaboration only
  // x = i/(depth-1) in Q0.32, result x^2 * fifth root of x, rounded
  function automatic logic [Q16_W-1:0] gamma_entry(int unsigned i, int unsigned depth);
    logic [63:0] den;
    logic [63:0] num;
    logic [63:0] rem;
    logic [63:0] x;
    logic [63:0] sq;
    logic [63:0] root;
    logic [63:0] c;
    logic [63:0] c2;
    logic [63:0] c4;
    logic [63:0] c5;
    logic [63:0] y;
    int b;
    den  = 64'(depth - 1);
    num  = 64'(i) << 32;
    rem  = '0;
    x    = '0;
    // long division of i * 2^32 by depth-1
    for (b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem  = rem - den;
        x[b] = 1'b1;
      end
    end
    if (x >= 64'h1_0000_0000) begin
      return Q16_ONE;
    end
    sq   = (x * x) >> 32;
    root = '0;
    for (b = 31; b >= 0; b--) begin
      c  = root | (64'd1 << b);
      c2 = (c * c) >> 32;
      c4 = (c2 * c2) >> 32;
      c5 = (c4 * c) >> 32;
      if (c5 <= x) begin
        root = c;
      end
    end
    y = (sq * root) >> 32;
    return Q16_W'((y + 64'd32768) >> 16);
  endfunction

endpackage

// File: design/idsc_if.sv
// ---------------------------------------------------------------------------
// idsc channel interfaces
// Valid/ready channels for input items, results and register writes.
// ---------------------------------------------------------------------------
interface idsc_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [31:0] now_ms;

  modport source (output valid, output func, output now_ms, input ready);
  modport sink   (input valid, input func, input now_ms, output ready);
endinterface

interface idsc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] power_state;
  logic       send_contrast;
  logic [7:0] contrast_value;
  logic       send_display_off;

  modport source (output valid, output power_state, output send_contrast,
                  output contrast_value, output send_display_off, input ready);
  modport sink   (input valid, input power_state, input send_contrast,
                  input contrast_value, input send_display_off, output ready);
endinterface

interface idsc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [23:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: design/idsc_gamma_rom.sv
// ---------------------------------------------------------------------------
// idsc_gamma_rom
// Constant gamma 2.2 curve, Q1.16 entries, registered read.
// ---------------------------------------------------------------------------
module idsc_gamma_rom import idsc_pkg::*; #(
  parameter int unsigned GAMMA_TABLE_DEPTH = GAMMA_DEPTH_DEF,
  localparam int unsigned IdxW = $clog2(GAMMA_TABLE_DEPTH)
) (
  input  logic             clk_i,
  input  logic             rd_en_i,
  input  logic [IdxW-1:0]  rd_addr_i,
  output logic [Q16_W-1:0] rd_data_o
);

  logic [Q16_W-1:0] rom [GAMMA_TABLE_DEPTH];
  logic [Q16_W-1:0] rd_data_q;

  for (genvar g = 0; g < GAMMA_TABLE_DEPTH; g++) begin : g_tab
    assign rom[g] = gamma_entry(g, GAMMA_TABLE_DEPTH);
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= rom[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: design/idle_dim_sleep_controller.sv
// ---------------------------------------------------------------------------
// idle_dim_sleep_controller
// Display idle controller: dims along a gamma 2.2 curve, then switches off.
// ---------------------------------------------------------------------------
// latency, accepting edge to result valid: an activity runs the idle and activity
//   steps; an active tick adds the dim compare and a sleep tick the sleep compare;
//   a dimming tick adds the bit-serial progress divider, skipped on saturation
// throughput: one item at a time, the next one taken the cycle after the result
//   step; a held result stalls only the next result
// reset: mode active, contrast 255, last activity 0, registers at defaults
module idle_dim_sleep_controller import idsc_pkg::*; #(
  parameter int unsigned TIME_BITS         = TIME_BITS_DEF,
  parameter int unsigned GAMMA_TABLE_DEPTH = GAMMA_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  idsc_in_if.sink     in_i,
  idsc_out_if.source  out_o,
  idsc_cfg_if.sink    cfg_i
);

  localparam int unsigned IdxW  = $clog2(GAMMA_TABLE_DEPTH);
  localparam int unsigned CmpW  = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;
  localparam int unsigned ProdW = Q16_W + IdxW + 1;

  // configuration registers
  logic [CFG_W-1:0] dim_q, sleep_q, fade_q;

  // sequencer
  step_t  pc_q, pc_d;
  ucode_t uw;
  logic   cond_ok, stall, in_fire, out_fire, out_busy, res_op;

  // datapath
  logic                  func_q;
  logic [TIME_BITS-1:0]  now_q, last_q, last_d, idle_q, idle_d;
  logic [CFG_W-1:0]      rem_q, rem_d;
  logic [Q16_W-1:0]      frac_q, frac_d;   // progress, then rest 1-p
  logic [DIV_CNT_W-1:0]  cnt_q, cnt_d;
  logic [IdxW-1:0]       idx_q, idx_d;
  logic [7:0]            target_q, target_d;
  logic [1:0]            mode_q, mode_d;
  logic [7:0]            contrast_q, contrast_d;
  logic [Q16_W-1:0]      entry;

  // output register
  logic       ovalid_q, ovalid_d;
  logic [1:0] ostate_q, ostate_d;
  logic       osend_q, osend_d;
  logic [7:0] ovalue_q, ovalue_d;
  logic       ooff_q, ooff_d;

  // comparisons and arithmetic helpers
  logic             lt_dim, lt_sleep, rem_ge;
  logic [CmpW-1:0]  elapsed_w;
  logic [CFG_W:0]   div_shift;
  logic             div_ge;
  logic [ProdW-1:0] idx_prod, idx_full;
  logic [24:0]      scale_prod;

  // register writes, always ready; index three and up is ignored
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q   <= DIM_START_RST;
      sleep_q <= SLEEP_RST;
      fade_q  <= FADE_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_DIM_START: dim_q   <= cfg_i.data;
        REG_SLEEP:     sleep_q <= cfg_i.data;
        REG_FADE:      fade_q  <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // control word of the current step
  assign uw = ucode(pc_q);

  assign in_i.ready = (uw.op == OP_WAIT);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_fire   = ovalid_q && out_o.ready;
  // result register still taken by an earlier transaction
  assign out_busy   = ovalid_q && !out_o.ready;
  assign res_op     = (uw.op == OP_DIMOUT) || (uw.op == OP_ACTIVITY) ||
                      (uw.op == OP_ACTIVE) || (uw.op == OP_SLEEP);
  assign stall      = ((uw.op == OP_WAIT) && !in_fire) || (res_op && out_busy);

  // idle time against the thresholds, compared at full width
  assign lt_dim    = CmpW'(idle_q) < CmpW'(dim_q);
  assign lt_sleep  = CmpW'(idle_q) < CmpW'(sleep_q);
  assign rem_ge    = rem_q >= fade_q;
  assign elapsed_w = CmpW'(idle_q) - CmpW'(dim_q);

  // one restoring division step, remainder kept below the fade length
  assign div_shift = {rem_q, 1'b0};
  assign div_ge    = div_shift >= {1'b0, fade_q};

  // nearest table index for the rest fraction
  assign idx_prod = ProdW'(frac_q) * ProdW'(GAMMA_TABLE_DEPTH - 1) + ProdW'(32768);
  assign idx_full = idx_prod >> 16;

  // contrast = 254 * curve + 1
  assign scale_prod = 25'(CONTRAST_GAIN) * 25'(entry);

  always_comb begin
    unique case (uw.cond)
      C_NONE:     cond_ok = 1'b0;
      C_ALWAYS:   cond_ok = 1'b1;
      C_FUNC:     cond_ok = func_q;
      C_LT_DIM:   cond_ok = lt_dim;
      C_GE_SLEEP: cond_ok = !lt_sleep;
      C_REM_GE:   cond_ok = rem_ge;
      C_MORE:     cond_ok = (cnt_q != DIV_CNT_W'(1));
      default:    cond_ok = 1'b0;
    endcase
  end

  always_comb begin
    if (stall) begin
      pc_d = pc_q;
    end else if (cond_ok) begin
      pc_d = uw.target;
    end else begin
      pc_d = pc_q + step_t'(1);
    end
  end

  // datapath driven by the control word
  always_comb begin
    last_d     = last_q;
    idle_d     = idle_q;
    rem_d      = rem_q;
    frac_d     = frac_q;
    cnt_d      = cnt_q;
    idx_d      = idx_q;
    target_d   = target_q;
    mode_d     = mode_q;
    contrast_d = contrast_q;
    ovalid_d   = ovalid_q && !out_fire;
    ostate_d   = ostate_q;
    osend_d    = osend_q;
    ovalue_d   = ovalue_q;
    ooff_d     = ooff_q;

    if (!stall) begin
      unique case (uw.op)
        OP_WAIT, OP_NOP, OP_LOOKUP: ;
        OP_IDLE: begin
          idle_d = now_q - last_q;  // wraps modulo 2^TIME_BITS
        end
        OP_ELAPSED: begin
          rem_d  = elapsed_w[CFG_W-1:0];
          frac_d = '0;
          cnt_d  = DIV_STEPS;
        end
        OP_DIVSTEP: begin
          rem_d  = div_ge ? CFG_W'(div_shift - {1'b0, fade_q}) : div_shift[CFG_W-1:0];
          frac_d = {frac_q[Q16_W-2:0], div_ge};
          cnt_d  = cnt_q - DIV_CNT_W'(1);
        end
        OP_SAT: begin
          frac_d = Q16_ONE;  // zero fade length lands here too
        end
        OP_REST: begin
          frac_d = Q16_ONE - frac_q;
        end
        OP_INDEX: begin
          if (idx_full > ProdW'(GAMMA_TABLE_DEPTH - 1)) begin
            idx_d = IdxW'(GAMMA_TABLE_DEPTH - 1);
          end else begin
            idx_d = idx_full[IdxW-1:0];
          end
        end
        OP_SCALE: begin
          target_d = scale_prod[23:16] + 8'd1;
        end
        OP_DIMOUT: begin
          mode_d   = MODE_DIMMING;
          ovalid_d = 1'b1;
          ostate_d = MODE_DIMMING;
          ooff_d   = 1'b0;
          if (target_q != contrast_q) begin
            contrast_d = target_q;
            osend_d    = 1'b1;
            ovalue_d   = target_q;
          end else begin
            osend_d  = 1'b0;
            ovalue_d = '0;
          end
        end
        OP_ACTIVITY: begin
          // contrast marked full, nothing sent
          last_d     = now_q;
          mode_d     = MODE_ACTIVE;
          contrast_d = CONTRAST_FULL;
          ovalid_d   = 1'b1;
          ostate_d   = MODE_ACTIVE;
          osend_d    = 1'b0;
          ovalue_d   = '0;
          ooff_d     = 1'b0;
        end
        OP_ACTIVE: begin
          mode_d   = MODE_ACTIVE;
          ovalid_d = 1'b1;
          ostate_d = MODE_ACTIVE;
          ooff_d   = 1'b0;
          if ((mode_q != MODE_ACTIVE) && (contrast_q != CONTRAST_FULL)) begin
            contrast_d = CONTRAST_FULL;
            osend_d    = 1'b1;
            ovalue_d   = CONTRAST_FULL;
          end else begin
            osend_d  = 1'b0;
            ovalue_d = '0;
          end
        end
        OP_SLEEP: begin
          // display-off goes out only on entry to sleep
          mode_d   = MODE_SLEEP;
          ovalid_d = 1'b1;
          ostate_d = MODE_SLEEP;
          osend_d  = 1'b0;
          ovalue_d = '0;
          ooff_d   = (mode_q != MODE_SLEEP);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q       <= STEP_WAIT;
      last_q     <= '0;
      mode_q     <= MODE_ACTIVE;
      contrast_q <= CONTRAST_FULL;
      ovalid_q   <= 1'b0;
      cnt_q      <= '0;
    end else begin
      pc_q       <= pc_d;
      last_q     <= last_d;
      mode_q     <= mode_d;
      contrast_q <= contrast_d;
      ovalid_q   <= ovalid_d;
      cnt_q      <= cnt_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      func_q <= in_i.func;
      now_q  <= TIME_BITS'(in_i.now_ms);
    end
    idle_q   <= idle_d;
    rem_q    <= rem_d;
    frac_q   <= frac_d;
    idx_q    <= idx_d;
    target_q <= target_d;
    ostate_q <= ostate_d;
    osend_q  <= osend_d;
    ovalue_q <= ovalue_d;
    ooff_q   <= ooff_d;
  end

  // curve lookup, data ready in the step after the lookup step
  idsc_gamma_rom #(
    .GAMMA_TABLE_DEPTH(GAMMA_TABLE_DEPTH)
  ) u_gamma_rom (
    .clk_i     (clk_i),
    .rd_en_i   (uw.op == OP_LOOKUP),
    .rd_addr_i (idx_q),
    .rd_data_o (entry)
  );

  assign out_o.valid            = ovalid_q;
  assign out_o.power_state      = ostate_q;
  assign out_o.send_contrast    = osend_q;
  assign out_o.contrast_value   = ovalue_q;
  assign out_o.send_display_off = ooff_q;

endmodule

// File: design/idsc_checker.sv
// ---------------------------------------------------------------------------
// idsc_checker
// Port-level assertions on the result channel of the idle controller.
// ---------------------------------------------------------------------------
module idsc_checker import idsc_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [1:0] power_state_i,
  input logic       send_contrast_i,
  input logic [7:0] contrast_value_i,
  input logic       send_display_off_i
);

  // at most one command per result
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(send_contrast_i && send_display_off_i))
    else $error("contrast and display-off in one result");

  // display-off only together with sleep
  a_off_sleep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && send_display_off_i) |-> (power_state_i == MODE_SLEEP))
    else $error("display-off outside sleep");

  // a contrast command never carries zero and never happens in sleep
  a_contrast_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && send_contrast_i) |->
      ((contrast_value_i != 8'd0) && (power_state_i != MODE_SLEEP)))
    else $error("bad contrast command");

  // no command means a zero contrast byte
  a_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !send_contrast_i) |-> (contrast_value_i == 8'd0))
    else $error("contrast byte without command");

  // a stalled result holds its valid, power state and contrast byte
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(power_state_i) && $stable(contrast_value_i)))
    else $error("result changed under stall");

endmodule

bind idle_dim_sleep_controller idsc_checker u_idsc_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .out_valid_i        (out_o.valid),
  .out_ready_i        (out_o.ready),
  .power_state_i      (out_o.power_state),
  .send_contrast_i    (out_o.send_contrast),
  .contrast_value_i   (out_o.contrast_value),
  .send_display_off_i (out_o.send_display_off)
);
